// ===== src/lfa_pkg.sv =====
package lfa_pkg;

	localparam int SIGMOID_SEGMENTS_DEF = 64;
	localparam longint ZLIM = 524288;
	localparam int NUM_TERMS = 10;
	localparam int QUEUE_DEPTH = 2;

	localparam logic signed [31:0] SCALE_RST = 32'sd65536;
	localparam logic signed [31:0] SLOPE_RST = 32'sd65536;
	localparam logic signed [31:0] OFFSET_RST = 32'sd0;

	typedef enum logic [1:0] {
		REG_SCALE  = 2'd0,
		REG_SLOPE  = 2'd1,
		REG_OFFSET = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] scale;
		logic signed [31:0] slope;
		logic signed [31:0] offset;
	} theta_t;

	typedef struct packed {
		logic [16:0]        weight;
		logic               last;
		logic [16:0]        s;
		logic signed [47:0] g1;
		logic signed [31:0] g2;
	} point_t;

	// upper-triangle walk of the 4x4 matrix
	function automatic logic [1:0] term_row(input logic [3:0] t);
		logic [1:0] r;
		case (t)
			4'd0, 4'd1, 4'd2, 4'd3: r = 2'd0;
			4'd4, 4'd5, 4'd6:       r = 2'd1;
			4'd7, 4'd8:             r = 2'd2;
			4'd9:                   r = 2'd3;
			default:                r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] term_col(input logic [3:0] t);
		logic [1:0] c;
		case (t)
			4'd0:             c = 2'd0;
			4'd1, 4'd4:       c = 2'd1;
			4'd2, 4'd5, 4'd7: c = 2'd2;
			4'd3, 4'd6, 4'd8, 4'd9: c = 2'd3;
			default:          c = 2'd0;
		endcase
		return c;
	endfunction

	// shift-subtract quotient for the elaboration-time table build
	function automatic logic [63:0] const_udiv(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= 65'(den)) begin
				rem = rem - 65'(den);
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// 1/(1+exp(t)) in Q0.16 for t >= 0, evaluated at elaboration only
	function automatic logic [16:0] pos_sigmoid(input logic [63:0] t);
		logic [63:0] sum;
		logic [63:0] term;
		logic [63:0] d;
		sum = 64'h1_0000_0000;
		term = sum;
		for (int n = 1; n <= 40; n++) begin
			term = const_udiv((term * t) >> 16, 64'(n));
			sum = sum + term;
		end
		d = 64'h1_0000_0000 + sum;
		return 17'(const_udiv(64'h1_0000_0000_0000 + (d >> 1), d));
	endfunction

endpackage

// ===== src/lfa_front.sv =====
module lfa_front #(
	parameter int SIGMOID_SEGMENTS = lfa_pkg::SIGMOID_SEGMENTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lfa_pkg::theta_t     theta,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  x_point,
	input  logic [16:0]         weight,
	input  logic                last_point,
	output logic                push_valid,
	input  logic                push_ready,
	output lfa_pkg::point_t     push_data
);

	localparam int KW = $clog2(SIGMOID_SEGMENTS);
	localparam int UW = 20 + $clog2(SIGMOID_SEGMENTS + 1);

	typedef logic [33:0] tbl_t [SIGMOID_SEGMENTS];

	function automatic logic [16:0] node_val(input int n);
		longint t;
		t = longint'(lfa_pkg::const_udiv(64'(n) << 20, 64'(SIGMOID_SEGMENTS))) - lfa_pkg::ZLIM;
		if (t >= 0)
			return lfa_pkg::pos_sigmoid(64'(t));
		return 17'd65536 - lfa_pkg::pos_sigmoid(64'(-t));
	endfunction

	// each segment holds its start value and its clamped drop
	function automatic tbl_t build_tbl();
		tbl_t tb;
		logic [16:0] a;
		logic [16:0] b;
		for (int n = 0; n < SIGMOID_SEGMENTS; n++) begin
			a = node_val(n);
			b = node_val(n + 1);
			tb[n] = {a, (a >= b) ? 17'(a - b) : 17'd0};
		end
		return tb;
	endfunction

	localparam tbl_t SEG_TBL = build_tbl();

	typedef enum logic [3:0] {
		F_IDLE, F_ZMUL, F_SEG, F_ROM, F_INTERP, F_QPROD, F_G2, F_G1, F_PUSH
	} fstate_t;

	fstate_t            state_q;
	logic signed [31:0] x_q;
	logic [16:0]        w_q;
	logic               last_q;
	logic signed [63:0] mul_q;
	logic [KW-1:0]      k_q;
	logic [19:0]        r_q;
	logic               hi_q;
	logic               lo_q;
	logic [33:0]        tbl_q;
	logic [16:0]        s_q;
	logic signed [31:0] g2_q;

	logic signed [48:0] z_c;
	logic [19:0]        off_c;
	logic [UW-1:0]      u_c;
	logic [36:0]        dr_c;
	logic [16:0]        s_c;
	logic signed [64:0] g2p_c;
	logic signed [63:0] g1p_c;

	always_comb begin
		z_c = 49'(mul_q >>> 16) + 49'(theta.offset);
		off_c = 20'(z_c + 49'sd524288);
		u_c = UW'(off_c) * UW'(SIGMOID_SEGMENTS);
		dr_c = 37'(tbl_q[16:0]) * 37'(r_q);
		if (hi_q)
			s_c = 17'd0;
		else if (lo_q)
			s_c = 17'd65536;
		else
			s_c = tbl_q[33:17] - dr_c[36:20];
		g2p_c = theta.scale * $signed({1'b0, mul_q[31:0]});
		g1p_c = $signed(mul_q[63:32]) * x_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE:   if (in_valid) state_q <= F_ZMUL;
				F_ZMUL:   state_q <= F_SEG;
				F_SEG:    state_q <= F_ROM;
				F_ROM:    state_q <= F_INTERP;
				F_INTERP: state_q <= F_QPROD;
				F_QPROD:  state_q <= F_G2;
				F_G2:     state_q <= F_G1;
				F_G1:     state_q <= F_PUSH;
				F_PUSH:   if (push_ready) state_q <= F_IDLE;
				default:  state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				x_q <= x_point;
				w_q <= weight;
				last_q <= last_point;
			end
			F_ZMUL:   mul_q <= theta.slope * x_q;
			F_SEG: begin
				hi_q <= (z_c >= 49'sd524288);
				lo_q <= (z_c < -49'sd524288);
				k_q <= u_c[20 +: KW];
				r_q <= u_c[19:0];
			end
			F_ROM:    tbl_q <= SEG_TBL[k_q];
			F_INTERP: s_q <= s_c;
			F_QPROD:  mul_q <= $signed(64'(34'(s_q) * 34'(17'd65536 - s_q)));
			// g2 = floor(-theta1*q / 2^32) is the upper word
			F_G2:     mul_q <= 64'(-g2p_c);
			F_G1: begin
				g2_q <= mul_q[63:32];
				mul_q <= g1p_c;
			end
			default: ;
		endcase
	end

	assign in_ready = (state_q == F_IDLE);
	assign push_valid = (state_q == F_PUSH);
	assign push_data.weight = w_q;
	assign push_data.last = last_q;
	assign push_data.s = s_q;
	assign push_data.g1 = mul_q[63:16];
	assign push_data.g2 = g2_q;

	a_s_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_QPROD) |-> (s_q <= 17'd65536))
		else $error("sigmoid out of range");

	a_hold_push: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_PUSH && !push_ready) |=> (state_q == F_PUSH && $stable(mul_q)))
		else $error("point lost while queue full");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_ZMUL) |-> $past(in_valid && state_q == F_IDLE))
		else $error("work started without accepted point");

endmodule

// ===== src/lfa_queue.sv =====
module lfa_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  lfa_pkg::point_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output lfa_pkg::point_t pop_data
);

	localparam int AW = $clog2(lfa_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(lfa_pkg::QUEUE_DEPTH + 1);

	lfa_pkg::point_t mem_q [lfa_pkg::QUEUE_DEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [CW-1:0]   count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != CW'(lfa_pkg::QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == AW'(lfa_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == AW'(lfa_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

endmodule

// ===== src/lfa_back.sv =====
module lfa_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  lfa_pkg::point_t pop_data,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [63:0]     res_sum [lfa_pkg::NUM_TERMS],
	output logic            res_sat
);

	typedef enum logic [2:0] {B_IDLE, B_WG, B_PP, B_ACC, B_OUT} bstate_t;

	localparam logic [63:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SUM_MIN = 64'h8000_0000_0000_0000;

	bstate_t      state_q;
	logic [1:0]   i_q;
	logic [3:0]   t_q;
	logic [1:0]   p_q;
	logic [63:0]  sums_q [lfa_pkg::NUM_TERMS];
	logic         sat_q;
	logic         out_valid_q;
	logic [63:0]  outs_q [lfa_pkg::NUM_TERMS];
	logic         out_sat_q;

	logic [47:0]  absg_q [4];
	logic         neg_q [4];
	logic [64:0]  wg_q [4];
	logic [16:0]  w_q;
	logic         last_q;
	logic [112:0] acc_q;

	logic [1:0]   row_c;
	logic [1:0]   col_c;
	logic [64:0]  a_c;
	logic [47:0]  b_c;
	logic [64:0]  pp_c;
	logic [112:0] pps_c;
	logic         tsat_c;
	logic [62:0]  mag_c;
	logic [63:0]  term_c;
	logic [64:0]  sum65_c;
	logic         ovf_c;
	logic [63:0]  nsum_c;
	logic [32:0]  g2abs_c;
	logic         out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		row_c = lfa_pkg::term_row(t_q);
		col_c = lfa_pkg::term_col(t_q);
		a_c = wg_q[row_c];
		b_c = absg_q[col_c];
		case (p_q)
			2'd0: begin
				pp_c = 65'(a_c[31:0]) * 65'(b_c[31:0]);
				pps_c = 113'(pp_c);
			end
			2'd1: begin
				pp_c = 65'(a_c[64:32]) * 65'(b_c[31:0]);
				pps_c = 113'(pp_c) << 32;
			end
			2'd2: begin
				pp_c = 65'(a_c[31:0]) * 65'(b_c[47:32]);
				pps_c = 113'(pp_c) << 32;
			end
			default: begin
				pp_c = 65'(a_c[64:32]) * 65'(b_c[47:32]);
				pps_c = 113'(pp_c) << 64;
			end
		endcase
		// clamp the term magnitude, then apply its sign and add with saturation
		tsat_c = |acc_q[112:79];
		mag_c = tsat_c ? 63'h7FFF_FFFF_FFFF_FFFF : acc_q[78:16];
		term_c = (neg_q[row_c] ^ neg_q[col_c]) ? -{1'b0, mag_c} : {1'b0, mag_c};
		sum65_c = {sums_q[t_q][63], sums_q[t_q]} + {term_c[63], term_c};
		ovf_c = sum65_c[64] ^ sum65_c[63];
		if (ovf_c)
			nsum_c = sum65_c[64] ? SUM_MIN : SUM_MAX;
		else
			nsum_c = sum65_c[63:0];
		g2abs_c = pop_data.g2[31] ? -{pop_data.g2[31], pop_data.g2}
			: {pop_data.g2[31], pop_data.g2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			i_q <= '0;
			t_q <= '0;
			p_q <= '0;
			sat_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int n = 0; n < lfa_pkg::NUM_TERMS; n++)
				sums_q[n] <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != B_OUT)
				out_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						i_q <= '0;
						state_q <= B_WG;
					end
				end
				B_WG: begin
					i_q <= i_q + 1'b1;
					if (i_q == 2'd3) begin
						t_q <= '0;
						p_q <= '0;
						state_q <= B_PP;
					end
				end
				B_PP: begin
					p_q <= p_q + 1'b1;
					if (p_q == 2'd3)
						state_q <= B_ACC;
				end
				B_ACC: begin
					sums_q[t_q] <= nsum_c;
					sat_q <= sat_q | tsat_c | ovf_c;
					if (t_q == 4'(lfa_pkg::NUM_TERMS - 1)) begin
						state_q <= last_q ? B_OUT : B_IDLE;
					end else begin
						t_q <= t_q + 1'b1;
						p_q <= '0;
						state_q <= B_PP;
					end
				end
				B_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						sat_q <= 1'b0;
						for (int n = 0; n < lfa_pkg::NUM_TERMS; n++)
							sums_q[n] <= '0;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				w_q <= pop_data.weight;
				last_q <= pop_data.last;
				absg_q[0] <= 48'(pop_data.s);
				absg_q[1] <= pop_data.g1[47] ? 48'(-pop_data.g1) : 48'(pop_data.g1);
				absg_q[2] <= 48'(g2abs_c);
				absg_q[3] <= 48'd65536;
				neg_q[0] <= 1'b0;
				neg_q[1] <= pop_data.g1[47];
				neg_q[2] <= pop_data.g2[31];
				neg_q[3] <= 1'b0;
			end
			B_WG: begin
				wg_q[i_q] <= 65'(w_q) * 65'(absg_q[i_q]);
				acc_q <= '0;
			end
			B_PP:  acc_q <= acc_q + pps_c;
			B_ACC: acc_q <= '0;
			B_OUT: begin
				if (out_free) begin
					for (int n = 0; n < lfa_pkg::NUM_TERMS; n++)
						outs_q[n] <= sums_q[n];
					out_sat_q <= sat_q;
				end
			end
			default: ;
		endcase
	end

	assign pop_ready = (state_q == B_IDLE);
	assign out_valid = out_valid_q;
	assign res_sum = outs_q;
	assign res_sat = out_sat_q;

	a_term_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_PP || state_q == B_ACC) |-> (t_q < 4'(lfa_pkg::NUM_TERMS)))
		else $error("term index out of range");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_OUT && out_free) |=> (out_valid_q && !sat_q && sums_q[0] == 64'd0
			&& sums_q[9] == 64'd0))
		else $error("sums not cleared after result");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == B_OUT))
		else $error("result raised outside output step");

endmodule

// ===== src/logistic4_fisher_info_accumulator.sv =====
// The back end sets the pace: it forms the ten weighted outer-product terms through one
// shared 33x32 multiplier, four partials a term. The front end (sigmoid and gradient) runs
// ahead through a two-entry queue, so it can take new points while the back end is busy.
// Reset (arst_n low, asynchronous) clears the sums, the saturation flag and all control
// state and restores the parameter registers to 1.0, 1.0 and 0.
module logistic4_fisher_info_accumulator #(
	parameter int SIGMOID_SEGMENTS = lfa_pkg::SIGMOID_SEGMENTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [31:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] x_point,
	input  logic [16:0]        weight,
	input  logic               last_point,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] m00,
	output logic signed [63:0] m01,
	output logic signed [63:0] m02,
	output logic signed [63:0] m03,
	output logic signed [63:0] m11,
	output logic signed [63:0] m12,
	output logic signed [63:0] m13,
	output logic signed [63:0] m22,
	output logic signed [63:0] m23,
	output logic signed [63:0] m33,
	output logic               saturated
);

	lfa_pkg::theta_t theta_q;
	logic            push_valid;
	logic            push_ready;
	lfa_pkg::point_t push_data;
	logic            pop_valid;
	logic            pop_ready;
	lfa_pkg::point_t pop_data;
	logic [63:0]     res_sum [lfa_pkg::NUM_TERMS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			theta_q.scale <= lfa_pkg::SCALE_RST;
			theta_q.slope <= lfa_pkg::SLOPE_RST;
			theta_q.offset <= lfa_pkg::OFFSET_RST;
		end else if (cfg_we) begin
			case (lfa_pkg::reg_idx_t'(cfg_idx))
				lfa_pkg::REG_SCALE:  theta_q.scale <= cfg_wdata;
				lfa_pkg::REG_SLOPE:  theta_q.slope <= cfg_wdata;
				lfa_pkg::REG_OFFSET: theta_q.offset <= cfg_wdata;
				default: ;
			endcase
		end
	end

	lfa_front #(
		.SIGMOID_SEGMENTS(SIGMOID_SEGMENTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.theta      (theta_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.x_point    (x_point),
		.weight     (weight),
		.last_point (last_point),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	lfa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	lfa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_sum   (res_sum),
		.res_sat   (saturated)
	);

	assign m00 = res_sum[0];
	assign m01 = res_sum[1];
	assign m02 = res_sum[2];
	assign m03 = res_sum[3];
	assign m11 = res_sum[4];
	assign m12 = res_sum[5];
	assign m13 = res_sum[6];
	assign m22 = res_sum[7];
	assign m23 = res_sum[8];
	assign m33 = res_sum[9];

endmodule

// ===== sim/logistic4_fisher_info_accumulator_tb.sv =====
module logistic4_fisher_info_accumulator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SEGS = 64;
	localparam longint HALF_RANGE = 524288;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE_CYCLES = 400;

	typedef struct {
		longint m[10];
		bit     sat;
	} fisher_matrix_t;

	class fisher_scoreboard;
		longint theta_amp, theta_slope, theta_off;
		longint sums[10];
		bit sat_seen;
		longint node_tab[SEGS + 1];
		int row_of[10];
		int col_of[10];
		string field_name[10];
		fisher_matrix_t pending[$];
		int errors;

		function new();
			row_of = '{0, 0, 0, 0, 1, 1, 1, 2, 2, 3};
			col_of = '{0, 1, 2, 3, 1, 2, 3, 2, 3, 3};
			field_name = '{"m00", "m01", "m02", "m03", "m11", "m12", "m13", "m22", "m23", "m33"};
			theta_amp = 65536;
			theta_slope = 65536;
			theta_off = 0;
			foreach (sums[i]) sums[i] = 0;
			sat_seen = 0;
			errors = 0;
			for (int n = 0; n <= SEGS; n++) node_tab[n] = node_val(n);
		endfunction

		function void set_param(lfa_pkg::reg_idx_t idx, logic [31:0] v);
			case (idx)
				lfa_pkg::REG_SCALE:  theta_amp = $signed(v);
				lfa_pkg::REG_SLOPE:  theta_slope = $signed(v);
				lfa_pkg::REG_OFFSET: theta_off = $signed(v);
				default: ;
			endcase
		endfunction

		function longint unsigned exp_q32(longint unsigned t);
			longint unsigned acc, tm;
			acc = 64'h1_0000_0000;
			tm = acc;
			for (int n = 1; n <= 40; n++) begin
				tm = ((tm * t) >> 16) / longint'(n);
				acc += tm;
			end
			return acc;
		endfunction

		function longint half_sigmoid(longint unsigned t);
			longint unsigned d;
			d = 64'h1_0000_0000 + exp_q32(t);
			return longint'((64'h1_0000_0000_0000 + d / 2) / d);
		endfunction

		function longint node_val(int n);
			longint t;
			t = (longint'(n) * 1048576) / SEGS - HALF_RANGE;
			if (t >= 0) return half_sigmoid(t);
			return 65536 - half_sigmoid(-t);
		endfunction

		function longint sigmoid_q16(longint z);
			longint u, k, r, a, b, d;
			if (z >= HALF_RANGE) return 0;
			if (z < -HALF_RANGE) return 65536;
			u = (z + HALF_RANGE) * SEGS;
			k = u >> 20;
			r = u & 64'hF_FFFF;
			a = node_tab[k];
			b = node_tab[k + 1];
			d = (a >= b) ? a - b : 0;
			return a - ((d * r) >> 20);
		endfunction

		function longint weighted(longint unsigned w, longint gi, longint gj, inout bit sat);
			logic [127:0] p;
			longint unsigned ai, aj;
			bit neg;
			neg = (gi < 0) != (gj < 0);
			ai = (gi < 0) ? -gi : gi;
			aj = (gj < 0) ? -gj : gj;
			p = (128'(ai) * 128'(aj) * 128'(w)) >> 16;
			if (p > 128'h7FFF_FFFF_FFFF_FFFF) begin
				sat = 1;
				p = 128'h7FFF_FFFF_FFFF_FFFF;
			end
			return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
		endfunction

		function longint clamp_add(longint a, longint b, inout bit sat);
			logic signed [64:0] t;
			t = 65'(a) + 65'(b);
			// clamp on overflow, direction from the true sign
			if (t[64] != t[63]) begin
				sat = 1;
				return t[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
			end
			return t[63:0];
		endfunction

		function void accept_point(logic [31:0] xp, logic [16:0] w, bit last);
			longint x, z, s, q;
			longint g[4];
			bit sat;
			fisher_matrix_t res;
			x = $signed(xp);
			sat = sat_seen;
			z = ((theta_slope * x) >>> 16) + theta_off;
			s = sigmoid_q16(z);
			q = s * (65536 - s);
			g[0] = s;
			g[2] = (-(theta_amp * q)) >>> 32;
			g[1] = (g[2] * x) >>> 16;
			g[3] = 65536;
			for (int i = 0; i < 10; i++)
				sums[i] = clamp_add(sums[i], weighted(w, g[row_of[i]], g[col_of[i]], sat), sat);
			sat_seen = sat;
			if (last) begin
				foreach (sums[i]) begin
					res.m[i] = sums[i];
					sums[i] = 0;
				end
				res.sat = sat_seen;
				sat_seen = 0;
				pending.push_back(res);
			end
		endfunction

		function void check_result(fisher_matrix_t got);
			fisher_matrix_t exp_m;
			if (pending.size() == 0) begin
				$error("result with no request waiting");
				errors++;
				return;
			end
			exp_m = pending.pop_front();
			for (int i = 0; i < 10; i++)
				if (got.m[i] != exp_m.m[i]) begin
					$error("%s expected %0d actual %0d", field_name[i], exp_m.m[i], got.m[i]);
					errors++;
				end
			if (got.sat != exp_m.sat) begin
				$error("saturated expected %0d actual %0d", exp_m.sat, got.sat);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_idx;
	logic [31:0] cfg_wdata;
	logic in_valid, in_ready;
	logic signed [31:0] x_point;
	logic [16:0] weight;
	logic last_point;
	logic out_valid, out_ready;
	logic signed [63:0] m00, m01, m02, m03, m11, m12, m13, m22, m23, m33;
	logic saturated;

	fisher_scoreboard sb;
	bit quiet;
	int cycles;

	logistic4_fisher_info_accumulator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.x_point(x_point), .weight(weight), .last_point(last_point),
		.out_valid(out_valid), .out_ready(out_ready),
		.m00(m00), .m01(m01), .m02(m02), .m03(m03), .m11(m11), .m12(m12),
		.m13(m13), .m22(m22), .m23(m23), .m33(m33), .saturated(saturated)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("logistic4_fisher_info_accumulator: mismatch");
			$finish;
		end
	end

	always @(negedge clk) out_ready <= quiet || ($urandom_range(0, 99) >= 30);

	always @(posedge clk) begin
		fisher_matrix_t got;
		if (arst_n && out_valid && out_ready) begin
			got.m = '{m00, m01, m02, m03, m11, m12, m13, m22, m23, m33};
			got.sat = saturated;
			sb.check_result(got);
		end
	end

	function automatic bit take_break();
		return !quiet && $urandom_range(0, 99) < 30;
	endfunction

	task automatic send_point(input logic [31:0] xp, input logic [16:0] w, input bit last);
		@(negedge clk);
		while (take_break()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		x_point <= xp;
		weight <= w;
		last_point <= last;
		do @(posedge clk); while (!in_ready);
		sb.accept_point(xp, w, last);
	endtask

	// hold requests until every result is back, then let the pipeline empty
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_param(input lfa_pkg::reg_idx_t idx, input logic [31:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		sb.set_param(idx, v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_thetas(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
		write_param(lfa_pkg::REG_SCALE, a);
		write_param(lfa_pkg::REG_SLOPE, b);
		write_param(lfa_pkg::REG_OFFSET, c);
	endtask

	function automatic logic [31:0] pick_x();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
			default: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
		endcase
	endfunction

	function automatic logic [16:0] pick_w();
		case ($urandom_range(0, 7))
			0: return 17'd65536;
			1: return 17'($urandom_range(0, 131071));
			2: return 17'd0;
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic logic [31:0] pick_theta();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom();
			3: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			default: return $urandom_range(0, 32'h0000_4000) - 32'h0000_2000;
		endcase
	endfunction

	task automatic random_phase(input int items);
		int sent, len;
		sent = 0;
		while (sent < items) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			for (int i = 0; i < len; i++) send_point(pick_x(), pick_w(), i == len - 1);
			sent += len;
		end
	endtask

	initial begin
		sb = new();
		quiet = 0;
		cycles = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_idx = lfa_pkg::REG_SCALE;
		cfg_wdata = 0;
		in_valid = 0;
		x_point = 0;
		weight = 0;
		last_point = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: default thetas, field extremes, sigmoid saturation edges
		send_point(32'd0, 17'd65536, 1);
		send_point(32'h7FFF_FFFF, 17'd65536, 0);
		send_point(32'h8000_0000, 17'd131071, 0);
		send_point(32'd1, 17'd0, 1);
		send_point(32'd524288, 17'd65536, 0);
		send_point(32'd524287, 17'd65536, 0);
		send_point(-32'sd524288, 17'd65536, 0);
		send_point(-32'sd524289, 17'd65536, 1);
		drain();
		// tiny slope keeps z in range while x is huge: term and sum overflow
		set_thetas(32'h7FFF_FFFF, 32'd1, 32'd0);
		send_point(32'h7FFF_FFFF, 17'd131071, 0);
		send_point(32'h8000_0000, 17'd131071, 0);
		send_point(32'h7FFF_FFFF, 17'd131071, 1);
		send_point(32'd0, 17'd65536, 1);
		drain();
		set_thetas(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		send_point(32'h7FFF_FFFF, 17'd65536, 0);
		send_point(32'h8000_0000, 17'd131071, 1);
		drain();
		set_thetas(32'h0001_0000, 32'h0001_0000, 32'h8000_0000);
		send_point(32'd65536, 17'd65536, 1);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 0) set_thetas(32'h0001_0000, 32'h0001_0000, 32'd0);
			else if (ph == 1) set_thetas(32'h7FFF_FFFF, 32'd1, 32'd0);
			else set_thetas(pick_theta(), pick_theta(), pick_theta());
			quiet = (ph == 3);
			random_phase(215);
			quiet = 0;
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("logistic4_fisher_info_accumulator: match");
		else
			$display("logistic4_fisher_info_accumulator: mismatch");
		$finish;
	end
endmodule
